[sv/paids_pkg.sv]
// Package for the positional list block: sizes, codes, payload and control structs.
// Used by paids_cell and positional_array_insert_delete_search; depends on nothing.
`default_nettype none

package paids_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = 8;

	typedef enum logic [1:0] {
		F_DISPLAY = 2'd0,
		F_INSERT  = 2'd1,
		F_DELETE  = 2'd2,
		F_SEARCH  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_DISP
	} fsm_t;

	typedef enum logic [1:0] {
		C_HOLD,
		C_INS,
		C_DEL,
		C_ROT
	} cell_op_t;

	typedef struct packed {
		func_t              func;
		logic [6:0]         position;
		logic signed [31:0] item_value;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [5:0]         found_position;
		logic signed [31:0] element_value;
		logic [5:0]         element_count;
		logic               last;
	} res_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t           op;
		logic [IDX_W-1:0]   pos;
		logic signed [31:0] data;
		logic [CNT_W-1:0]   count;
	} cell_ctrl_t;

	// output fields are 6 bits; wider counts wrap
	function automatic logic [5:0] fit6(input logic [CNT_W-1:0] v);
		logic [CNT_W+5:0] w;
		w = {6'd0, v};
		return w[5:0];
	endfunction

endpackage

`default_nettype wire

[sv/paids_cell.sv]
// One storage cell of the list: holds one entry, shifts with its neighbors, compares for search.
// Depends on paids_pkg.
`default_nettype none

module paids_cell (
	input  logic                     clk,
	input  paids_pkg::cell_ctrl_t    ctrl,
	input  logic [paids_pkg::IDX_W-1:0] idx,
	input  logic signed [31:0]       left_val,
	input  logic signed [31:0]       right_val,
	input  logic signed [31:0]       head_val,
	output logic signed [31:0]       value,
	output logic                     hit
);

	logic signed [31:0]            value_q;
	logic signed [31:0]            value_d;
	logic [paids_pkg::CNT_W-1:0]   idx_ext;
	logic [paids_pkg::CNT_W-1:0]   idx_nxt;

	assign idx_ext = paids_pkg::CNT_W'(idx);
	assign idx_nxt = idx_ext + paids_pkg::CNT_W'(1);

	always_comb begin
		value_d = value_q;
		unique case (ctrl.op)
			paids_pkg::C_INS: begin
				if (idx > ctrl.pos) begin
					value_d = left_val;
				end else if (idx == ctrl.pos) begin
					value_d = ctrl.data;
				end
			end
			paids_pkg::C_DEL: begin
				if (idx >= ctrl.pos) begin
					value_d = right_val;
				end
			end
			paids_pkg::C_ROT: begin
				// rotate the occupied part one place toward cell 0
				if (idx_nxt == ctrl.count) begin
					value_d = head_val;
				end else if (idx_nxt < ctrl.count) begin
					value_d = right_val;
				end
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign hit   = (value_q == ctrl.data) && (idx_ext < ctrl.count);

endmodule

`default_nettype wire

[sv/positional_array_insert_delete_search.sv]
// Top level of the positional list: command decode, row of paids_cell, result register.
// Depends on paids_pkg and paids_cell.
`default_nettype none

// A command transfers on a rising edge with start high and busy low. Every
// result shows for exactly one cycle with done high; the receiver cannot hold
// it off. Insert and delete update the row of cells in the cycle they are
// taken, busy stays low, and the result follows in the next cycle, so a new
// command may come every cycle. Search raises busy while the first hit is
// found: all cells compare at once, the hit vector is registered, then the
// first hit is picked. Display holds busy until the last element and gives
// one element per cycle: the occupied cells rotate one place per cycle and
// cell 0 is read, which also leaves the list in its original order. Display
// of an empty list gives one empty result without raising busy.
module positional_array_insert_delete_search (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  paids_pkg::cmd_t  cmd,
	output logic             busy,
	output logic             done,
	output paids_pkg::res_t  result
);

	localparam int CAP = paids_pkg::CAPACITY;

	paids_pkg::fsm_t                state_q, state_d;
	logic [paids_pkg::CNT_W-1:0]    count_q, count_d;
	logic [paids_pkg::IDX_W-1:0]    disp_q, disp_d;
	logic [CAP-1:0]                 hit_s1;
	logic                           done_q, done_d;
	paids_pkg::res_t                res_q, res_d;
	paids_pkg::cell_ctrl_t          ctrl;
	logic signed [31:0]             vals [CAP];
	logic [CAP-1:0]                 hits;
	logic                           accept;
	logic [paids_pkg::CMP_W-1:0]    pos_c, cnt_c;
	logic                           ins_ok, del_ok, full;
	logic                           found;
	logic [paids_pkg::IDX_W-1:0]    fidx;
	logic [paids_pkg::CNT_W-1:0]    disp_ext;

	assign accept   = start && !busy;
	assign busy     = (state_q != paids_pkg::S_IDLE);
	assign pos_c    = paids_pkg::CMP_W'(cmd.position);
	assign cnt_c    = paids_pkg::CMP_W'(count_q);
	assign ins_ok   = (pos_c != '0) && (pos_c <= cnt_c + paids_pkg::CMP_W'(1));
	assign del_ok   = (pos_c != '0) && (pos_c <= cnt_c);
	assign full     = (count_q == paids_pkg::CNT_W'(CAP));
	assign disp_ext = paids_pkg::CNT_W'(disp_q);

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic signed [31:0] lv, rv;
		if (i == 0) begin : g_l0
			assign lv = vals[0];
		end else begin : g_l
			assign lv = vals[i-1];
		end
		if (i == CAP - 1) begin : g_rn
			assign rv = vals[i];
		end else begin : g_r
			assign rv = vals[i+1];
		end
		paids_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (paids_pkg::IDX_W'(i)),
			.left_val  (lv),
			.right_val (rv),
			.head_val  (vals[0]),
			.value     (vals[i]),
			.hit       (hits[i])
		);
	end

	// first hit: lowest index wins
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				found = 1'b1;
				fidx  = paids_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		disp_d    = disp_q;
		done_d    = 1'b0;
		res_d     = res_q;
		ctrl.op   = paids_pkg::C_HOLD;
		ctrl.pos  = paids_pkg::IDX_W'(cmd.position - 7'd1);
		ctrl.data = cmd.item_value;
		ctrl.count = count_q;
		unique case (state_q)
			paids_pkg::S_IDLE: begin
				if (accept) begin
					res_d.status         = paids_pkg::ST_OK;
					res_d.found_position = '0;
					res_d.element_value  = '0;
					res_d.element_count  = paids_pkg::fit6(count_q);
					res_d.last           = 1'b1;
					unique case (cmd.func)
						paids_pkg::F_DISPLAY: begin
							if (count_q == '0) begin
								res_d.status = paids_pkg::ST_EMPTY;
								done_d       = 1'b1;
							end else begin
								disp_d  = '0;
								state_d = paids_pkg::S_DISP;
							end
						end
						paids_pkg::F_INSERT: begin
							done_d = 1'b1;
							if (!ins_ok) begin
								res_d.status = paids_pkg::ST_INVALID;
							end else if (full) begin
								res_d.status = paids_pkg::ST_FULL;
							end else begin
								ctrl.op = paids_pkg::C_INS;
								count_d = count_q + paids_pkg::CNT_W'(1);
								res_d.element_count = paids_pkg::fit6(count_d);
							end
						end
						paids_pkg::F_DELETE: begin
							done_d = 1'b1;
							if (!del_ok) begin
								res_d.status = paids_pkg::ST_INVALID;
							end else begin
								ctrl.op = paids_pkg::C_DEL;
								count_d = count_q - paids_pkg::CNT_W'(1);
								res_d.element_count = paids_pkg::fit6(count_d);
							end
						end
						default: begin
							state_d = paids_pkg::S_SRCH;
						end
					endcase
				end
			end
			paids_pkg::S_SRCH: begin
				done_d               = 1'b1;
				state_d              = paids_pkg::S_IDLE;
				res_d.status         = found ? paids_pkg::ST_OK : paids_pkg::ST_NOTFOUND;
				res_d.found_position = found ?
					paids_pkg::fit6(paids_pkg::CNT_W'(fidx) + paids_pkg::CNT_W'(1)) : 6'd0;
				res_d.element_value  = '0;
				res_d.element_count  = paids_pkg::fit6(count_q);
				res_d.last           = 1'b1;
			end
			paids_pkg::S_DISP: begin
				done_d               = 1'b1;
				ctrl.op              = paids_pkg::C_ROT;
				res_d.status         = paids_pkg::ST_OK;
				res_d.found_position = paids_pkg::fit6(disp_ext + paids_pkg::CNT_W'(1));
				res_d.element_value  = vals[0];
				res_d.element_count  = paids_pkg::fit6(count_q);
				res_d.last           = (disp_ext + paids_pkg::CNT_W'(1) == count_q);
				disp_d               = disp_q + paids_pkg::IDX_W'(1);
				if (res_d.last) begin
					state_d = paids_pkg::S_IDLE;
				end
			end
			default: state_d = paids_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= paids_pkg::S_IDLE;
			count_q <= '0;
			disp_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			disp_q  <= disp_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			hit_s1 <= hits;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= paids_pkg::CNT_W'(CAP))
		else $error("count above capacity");

	a_disp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == paids_pkg::S_DISP) |-> (count_q != '0))
		else $error("display running on empty list");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != paids_pkg::ST_OK) |-> result.last)
		else $error("error status on non-final result");

	a_disp_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == paids_pkg::S_DISP && state_d == paids_pkg::S_IDLE) |=>
		(done && result.last))
		else $error("display ended without final result");

	a_srch_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == paids_pkg::S_SRCH) |=> (done && state_q == paids_pkg::S_IDLE))
		else $error("search did not complete");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Testbench for positional_array_insert_delete_search: directed and random list requests,
// checked against a queue-based model of the list. Depends on paids_pkg and the block RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int IDLE_LIMIT = 1000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	paids_pkg::cmd_t cmd = '0;
	logic busy;
	logic done;
	paids_pkg::res_t result;

	positional_array_insert_delete_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the list contents, front = position 1
	logic signed [31:0] stored_values[$];
	paids_pkg::res_t    pending_results[$];

	int  errors      = 0;
	int  n_requests  = 0;
	int  n_results   = 0;
	int  n_full      = 0;
	int  n_invalid   = 0;
	int  n_miss      = 0;
	int  n_empty     = 0;
	int  idle_cycles = 0;
	bit  no_gaps     = 1'b0;

	function automatic void queue_result(input paids_pkg::status_t st, input int pos,
		input logic signed [31:0] value, input bit is_last);
		paids_pkg::res_t r;
		r.status         = st;
		r.found_position = 6'(pos);
		r.element_value  = value;
		r.element_count  = 6'(stored_values.size());
		r.last           = is_last;
		pending_results.push_back(r);
		case (st)
			paids_pkg::ST_FULL:     n_full++;
			paids_pkg::ST_INVALID:  n_invalid++;
			paids_pkg::ST_NOTFOUND: n_miss++;
			paids_pkg::ST_EMPTY:    n_empty++;
			default: ;
		endcase
	endfunction

	// applies one request to the list model and queues what the block should return
	function automatic void apply_request(input paids_pkg::cmd_t c);
		int n;
		int p;
		int hit;
		n   = stored_values.size();
		p   = c.position;
		hit = 0;
		case (c.func)
			paids_pkg::F_DISPLAY: begin
				if (n == 0)
					queue_result(paids_pkg::ST_EMPTY, 0, 0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						queue_result(paids_pkg::ST_OK, i + 1, stored_values[i], i == n - 1);
			end
			paids_pkg::F_INSERT: begin
				if (p < 1 || p > n + 1)
					queue_result(paids_pkg::ST_INVALID, 0, 0, 1'b1);
				else if (n >= paids_pkg::CAPACITY)
					queue_result(paids_pkg::ST_FULL, 0, 0, 1'b1);
				else begin
					stored_values.insert(p - 1, c.item_value);
					queue_result(paids_pkg::ST_OK, 0, 0, 1'b1);
				end
			end
			paids_pkg::F_DELETE: begin
				if (p < 1 || p > n)
					queue_result(paids_pkg::ST_INVALID, 0, 0, 1'b1);
				else begin
					stored_values.delete(p - 1);
					queue_result(paids_pkg::ST_OK, 0, 0, 1'b1);
				end
			end
			default: begin
				for (int i = n - 1; i >= 0; i--)
					if (stored_values[i] == c.item_value)
						hit = i + 1;
				if (hit != 0)
					queue_result(paids_pkg::ST_OK, hit, 0, 1'b1);
				else
					queue_result(paids_pkg::ST_NOTFOUND, 0, 0, 1'b1);
			end
		endcase
	endfunction

	task automatic report_field(input string fname, input logic signed [31:0] want,
		input logic signed [31:0] got);
		$display("t=%0t %s: expected %0d, got %0d", $time, fname, want, got);
		errors++;
	endtask

	// results are checked before a new request is modeled, so a result can never
	// be matched against an expectation queued at the same edge
	always @(posedge clk) begin
		paids_pkg::res_t want;
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (pending_results.size() == 0) begin
					$display("t=%0t unexpected result: status %0d pos %0d value %0d", $time,
						result.status, result.found_position, result.element_value);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status)
						report_field("status", want.status, result.status);
					if (result.found_position !== want.found_position)
						report_field("found_position", want.found_position,
							result.found_position);
					if (result.element_value !== want.element_value)
						report_field("element_value", want.element_value,
							result.element_value);
					if (result.element_count !== want.element_count)
						report_field("element_count", want.element_count,
							result.element_count);
					if (result.last !== want.last)
						report_field("last", want.last, result.last);
				end
			end
			if (start && !busy) begin
				apply_request(cmd);
				n_requests++;
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("t=%0t timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("positional_array_insert_delete_search: mismatch");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// mostly a position inside 1..hi, sometimes anything the field can hold
	function automatic logic [6:0] rand_position(input int hi);
		if (hi < 1 || $urandom_range(0, 99) < 15)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(1, hi));
	endfunction

	// start stays high from one transfer to the next when there is no gap;
	// returns once the monitor has modeled the transfer, so the list model is current
	task automatic send_request(input paids_pkg::func_t f, input logic [6:0] pos,
		input logic signed [31:0] value);
		int gap;
		int seen;
		seen = n_requests;
		gap  = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		cmd.func       <= f;
		cmd.position   <= pos;
		cmd.item_value <= value;
		wait (n_requests != seen);
	endtask

	task automatic test_empty_list();
		send_request(paids_pkg::F_DISPLAY, 7'd0, 0);
		send_request(paids_pkg::F_SEARCH, 7'd0, 0);
		send_request(paids_pkg::F_DELETE, 7'd0, 0);
		send_request(paids_pkg::F_DELETE, 7'd1, 0);
		send_request(paids_pkg::F_INSERT, 7'd0, 32'sd5);
		send_request(paids_pkg::F_INSERT, 7'd2, 32'sd5);
		send_request(paids_pkg::F_INSERT, 7'd127, -1);
	endtask

	task automatic test_edges();
		send_request(paids_pkg::F_INSERT, 7'd1, 32'sh8000_0000);
		send_request(paids_pkg::F_INSERT, 7'd2, 32'sh7fff_ffff);
		send_request(paids_pkg::F_INSERT, 7'd1, 0);
		send_request(paids_pkg::F_INSERT, 7'd2, -1);
		send_request(paids_pkg::F_DISPLAY, 7'd127, 0);
		send_request(paids_pkg::F_SEARCH, 7'd0, -1);
		send_request(paids_pkg::F_SEARCH, 7'd9, 32'sh7fff_ffff);
		send_request(paids_pkg::F_SEARCH, 7'd0, 32'sd12345);
		send_request(paids_pkg::F_INSERT, 7'd6, 32'sd1);
		send_request(paids_pkg::F_DELETE, 7'd5, 0);
		send_request(paids_pkg::F_DELETE, 7'd4, 0);
		send_request(paids_pkg::F_DELETE, 7'd1, 0);
		send_request(paids_pkg::F_DELETE, 7'd127, 0);
		send_request(paids_pkg::F_DISPLAY, 7'd0, 0);
	endtask

	// fill to capacity with random content, push on the full list, then search, display and delete down to half
	task automatic test_full_list();
		int n;
		logic signed [31:0] dup;
		dup = rand_value();
		while (stored_values.size() < paids_pkg::CAPACITY) begin
			n = stored_values.size();
			if (n == 3 || n == 20)
				send_request(paids_pkg::F_INSERT, 7'($urandom_range(1, n + 1)), dup);
			else
				send_request(paids_pkg::F_INSERT, 7'($urandom_range(1, n + 1)),
					rand_value());
		end
		send_request(paids_pkg::F_INSERT, 7'($urandom_range(1, paids_pkg::CAPACITY)),
			rand_value());
		send_request(paids_pkg::F_INSERT, 7'(paids_pkg::CAPACITY + 1), rand_value());
		send_request(paids_pkg::F_INSERT, 7'(paids_pkg::CAPACITY + 2), rand_value());
		send_request(paids_pkg::F_SEARCH, 7'($urandom), dup);
		send_request(paids_pkg::F_DISPLAY, 7'($urandom), rand_value());
		send_request(paids_pkg::F_DELETE, 7'(paids_pkg::CAPACITY + 1), 0);
		send_request(paids_pkg::F_DELETE, 7'(paids_pkg::CAPACITY), 0);
		while (stored_values.size() > paids_pkg::CAPACITY / 2)
			send_request(paids_pkg::F_DELETE, 7'($urandom_range(1, stored_values.size())),
				rand_value());
	endtask

	task automatic test_random(input int n_items);
		int n;
		int r;
		logic signed [31:0] value;
		for (int k = 0; k < n_items; k++) begin
			if (k % 30 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			n = stored_values.size();
			r = $urandom_range(0, 99);
			value = rand_value();
			if (n > 0 && $urandom_range(0, 3) == 0)
				value = stored_values[$urandom_range(0, n - 1)];
			if (r < 8)
				send_request(paids_pkg::F_DISPLAY, 7'($urandom), value);
			else if (r < 33)
				send_request(paids_pkg::F_SEARCH, 7'($urandom), value);
			else if (r < ((n < paids_pkg::CAPACITY - 4) ? 73 : 50))
				send_request(paids_pkg::F_INSERT, rand_position(n + 1), value);
			else
				send_request(paids_pkg::F_DELETE, rand_position(n), value);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edges();
		test_full_list();
		test_random(80);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d results checked", n_requests, n_results);
		$display("status hits: full %0d, invalid %0d, not found %0d, empty display %0d",
			n_full, n_invalid, n_miss, n_empty);
		if (errors == 0)
			$display("positional_array_insert_delete_search: match");
		else
			$display("positional_array_insert_delete_search: mismatch");
		$finish;
	end

endmodule
